@@ rtl/dde_pkg.sv @@
// Package for the decimal digit emitter: item structs, register indexes,
// blank mode codes, sequencer states, cell control and the power-of-ten table.
// No dependencies.
`default_nettype none

package dde_pkg;

  localparam int VALUE_W     = 24;
  localparam int ADDR_W      = 16;
  localparam int POS_W       = 3;
  localparam int CODE_W      = 4;
  localparam int DIG_W       = 4;
  localparam int NDIG_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int POW10_W     = 27;
  localparam int BIT_CNT_W   = $clog2(VALUE_W);
  localparam int MAX_DIGITS_DEF = 6;

  localparam logic [NDIG_W-1:0] NUM_DIGITS_RST  = 3'd6;
  localparam logic [ADDR_W-1:0] ADDR_STRIDE_RST = 16'h0040;
  localparam logic [CODE_W-1:0] BLANK_CODE      = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIGITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_STRIDE = 2'd2;

  typedef enum logic [1:0] {
    BM_SKIP      = 2'd0,
    BM_BLANK     = 2'd1,
    BM_ALL       = 2'd2,
    BM_KEEP_LAST = 2'd3
  } blank_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ADDR_W-1:0]  base_addr;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ADDR_W-1:0] digit_addr;
    logic [CODE_W-1:0] digit_code;
    logic              last_digit;
    logic              overflowed;
  } out_item_t;

  typedef struct packed {
    logic clear;    // zero the digit
    logic dabble;   // add-3 correct, then shift one bit in
    logic advance;  // take the neighbor's digit
  } cell_ctrl_t;

  function automatic logic [POW10_W-1:0] pow10(input logic [3:0] n);
    logic [POW10_W-1:0] p;
    unique case (n)
      4'd0:    p = 27'd1;
      4'd1:    p = 27'd10;
      4'd2:    p = 27'd100;
      4'd3:    p = 27'd1000;
      4'd4:    p = 27'd10000;
      4'd5:    p = 27'd100000;
      4'd6:    p = 27'd1000000;
      4'd7:    p = 27'd10000000;
      4'd8:    p = 27'd100000000;
      default: p = 27'd100000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dde_cell.sv @@
// One BCD digit cell of the conversion chain.
// Depends on dde_pkg (cell_ctrl_t, DIG_W).
`default_nettype none

module dde_cell (
  input  wire                        clk,
  input  wire dde_pkg::cell_ctrl_t   ctrl,
  input  wire                        carry_in,
  output logic                       carry_out,
  input  wire [dde_pkg::DIG_W-1:0]   dig_in,
  output logic [dde_pkg::DIG_W-1:0]  dig_out
);

  logic [dde_pkg::DIG_W-1:0] dig_r;
  logic [dde_pkg::DIG_W-1:0] corr;

  // add 3 to digits of five or more so the shift stays decimal
  always_comb begin
    corr = (dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
  end

  assign carry_out = corr[dde_pkg::DIG_W-1];
  assign dig_out   = dig_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      dig_r <= '0;
    end else if (ctrl.dabble) begin
      dig_r <= {corr[dde_pkg::DIG_W-2:0], carry_in};
    end else if (ctrl.advance) begin
      dig_r <= dig_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/decimal_digit_emitter_blanking.sv @@
// Decimal digit emitter with leading-zero blanking: top level.
// Depends on dde_pkg and dde_cell.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, in_data           | taken when start && !busy
//  result   | out_valid, out_data            | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// From the accepting edge busy stays high while the value is shifted bit by
// bit through the chain of BCD cells (double dabble) and then while the
// digits are walked out, one digit per cycle (in skip mode leading zeros give
// no result). busy drops as the last digit is registered, so the next item
// may start while that result is on the output. Reset is synchronous, active
// low, and clears control state and the registers to their defaults. The
// receiver cannot stall the block.
`default_nettype none

module decimal_digit_emitter_blanking #(
  parameter int MAX_DIGITS = dde_pkg::MAX_DIGITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire dde_pkg::in_item_t           in_data,
  output logic                             out_valid,
  output dde_pkg::out_item_t               out_data,
  input  wire                              cfg_we,
  input  wire [dde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [dde_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [3:0] MAX_N = 4'(MAX_DIGITS);

  // configuration registers
  logic [dde_pkg::NDIG_W-1:0] num_digits_r;
  dde_pkg::blank_mode_t       blank_mode_r;
  logic [dde_pkg::ADDR_W-1:0] addr_stride_r;

  // control and item state
  dde_pkg::state_t               state_r, state_nxt;
  logic [dde_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [dde_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [dde_pkg::POS_W-1:0]     last_idx_r, last_idx_nxt;
  logic [dde_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [dde_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          seen_r, seen_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dde_pkg::out_item_t            out_data_r, out_data_nxt;

  // cell chain
  dde_pkg::cell_ctrl_t        cell_ctrl;
  logic                       carry [MAX_DIGITS+1];
  logic [dde_pkg::DIG_W-1:0]  cell_dig [MAX_DIGITS];

  // start-time values
  logic [3:0]                  n_eff;
  logic [dde_pkg::POW10_W-1:0] limit;
  logic                        too_big;
  logic [dde_pkg::VALUE_W-1:0] val_sat;

  // emit-time values
  logic [dde_pkg::DIG_W-1:0]   cur_dig;
  logic                        is_last;
  logic                        emit;
  logic [dde_pkg::CODE_W-1:0]  code;

  assign busy      = (state_r != dde_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_digits_r  <= dde_pkg::NUM_DIGITS_RST;
      blank_mode_r  <= dde_pkg::BM_SKIP;
      addr_stride_r <= dde_pkg::ADDR_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dde_pkg::CFG_NUM_DIGITS:  num_digits_r  <= cfg_data[dde_pkg::NDIG_W-1:0];
        dde_pkg::CFG_BLANK_MODE:  blank_mode_r  <= dde_pkg::blank_mode_t'(cfg_data[1:0]);
        dde_pkg::CFG_ADDR_STRIDE: addr_stride_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the digit count to 1..MAX_DIGITS and saturate the value
  always_comb begin
    n_eff = {1'b0, num_digits_r};
    if (n_eff == 4'd0) begin
      n_eff = 4'd1;
    end
    if (n_eff > MAX_N) begin
      n_eff = MAX_N;
    end
    limit   = dde_pkg::pow10(n_eff);
    too_big = ({3'b000, in_data.value} >= limit);
    val_sat = too_big ? dde_pkg::VALUE_W'(limit - 27'd1) : in_data.value;
  end

  // the chain: bits enter at cell 0 during conversion, digits move up
  // toward the most significant end during emission
  assign carry[0] = val_r[dde_pkg::VALUE_W-1];

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    logic [dde_pkg::DIG_W-1:0] dig_in;
    if (k == 0) begin : g_first
      assign dig_in = '0;
    end else begin : g_rest
      assign dig_in = cell_dig[k-1];
    end
    dde_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .carry_in  (carry[k]),
      .carry_out (carry[k+1]),
      .dig_in    (dig_in),
      .dig_out   (cell_dig[k])
    );
  end

  // current digit sits in the top cell of the active window
  assign cur_dig = cell_dig[last_idx_r[IDX_W-1:0]];
  assign is_last = (pos_r == last_idx_r);

  // leading-zero handling for the digit on show
  always_comb begin
    seen_nxt = seen_r | (cur_dig != 4'd0);
    code     = cur_dig;
    emit     = 1'b1;
    if (!seen_nxt) begin
      unique case (blank_mode_r)
        dde_pkg::BM_SKIP:      emit = 1'b0;
        dde_pkg::BM_BLANK:     code = dde_pkg::BLANK_CODE;
        dde_pkg::BM_ALL:       code = cur_dig;
        dde_pkg::BM_KEEP_LAST: code = is_last ? cur_dig : dde_pkg::BLANK_CODE;
        default:               code = cur_dig;
      endcase
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    bit_cnt_nxt   = bit_cnt_r;
    last_idx_nxt  = last_idx_r;
    pos_nxt       = pos_r;
    addr_nxt      = addr_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cell_ctrl     = '0;

    unique case (state_r)
      dde_pkg::ST_IDLE: begin
        if (start) begin
          val_nxt         = val_sat;
          addr_nxt        = in_data.base_addr;
          ovf_nxt         = too_big;
          last_idx_nxt    = dde_pkg::POS_W'(n_eff - 4'd1);
          bit_cnt_nxt     = '0;
          pos_nxt         = '0;
          cell_ctrl.clear = 1'b1;
          state_nxt       = dde_pkg::ST_CONV;
        end
      end
      dde_pkg::ST_CONV: begin
        // shift one value bit into the chain per cycle
        cell_ctrl.dabble = 1'b1;
        val_nxt          = {val_r[dde_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_nxt      = bit_cnt_r + dde_pkg::BIT_CNT_W'(1);
        if (bit_cnt_r == dde_pkg::BIT_CNT_W'(dde_pkg::VALUE_W - 1)) begin
          state_nxt = dde_pkg::ST_EMIT;
        end
      end
      dde_pkg::ST_EMIT: begin
        // register one digit, advance the chain and the address
        cell_ctrl.advance       = 1'b1;
        out_valid_nxt           = emit;
        out_data_nxt.position   = pos_r;
        out_data_nxt.digit_addr = addr_r;
        out_data_nxt.digit_code = code;
        out_data_nxt.last_digit = is_last;
        out_data_nxt.overflowed = ovf_r;
        addr_nxt                = addr_r + addr_stride_r;
        pos_nxt                 = pos_r + dde_pkg::POS_W'(1);
        if (is_last) begin
          state_nxt = dde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dde_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // forget leading-zero history when a new item starts
      if (state_r == dde_pkg::ST_EMIT) begin
        seen_r <= seen_nxt;
      end else begin
        seen_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    last_idx_r <= last_idx_nxt;
    pos_r      <= pos_nxt;
    addr_r     <= addr_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  // results come only out of the emit phase
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == dde_pkg::ST_EMIT))
    else $error("result outside emit phase");

  // the final digit of an item always leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_digit) |-> (state_r == dde_pkg::ST_IDLE))
    else $error("last digit while still busy");

  // the saturated value must fit the chain: nothing carries off the top
  a_no_chain_spill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dde_pkg::ST_CONV) |-> !carry[MAX_DIGITS])
    else $error("digit chain overflow");

  // an accepted item moves straight into conversion
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == dde_pkg::ST_CONV))
    else $error("accepted item not converting");
`endif

endmodule

`default_nettype wire
